@@ design/npce_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// npce_pkg: shared types and constants of the nibble prefix-code encoder
// Holds the code table layout, the queue entry format and register indexes.
// ---------------------------------------------------------------------------
package npce_pkg;

    // Code table geometry.
    localparam int SYMBOL_COUNT    = 16;
    localparam int MAX_CODE_LENGTH = 15;

    // Configuration register indexes.
    localparam int REG_COUNT = 5;
    localparam logic [2:0] REG_CODES_0  = 3'd0;
    localparam logic [2:0] REG_CODES_1  = 3'd1;
    localparam logic [2:0] REG_CODES_2  = 3'd2;
    localparam logic [2:0] REG_CODES_3  = 3'd3;
    localparam logic [2:0] REG_LENGTHS  = 3'd4;

    // Five output bytes cover the largest batch one input byte can cause.
    localparam int WORD_W = 40;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [3:0][63:0] codes;
        logic [63:0]      lengths;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [2:0]        cnt;
        logic              fin;
    } entry_t;

endpackage : npce_pkg
`default_nettype wire

@@ design/nibble_prefix_code_encoder_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// nibble_prefix_code_encoder_top: static prefix-code encoder, 4-bit symbols
// Encodes each input byte as two codewords and packs them into bytes.
// ---------------------------------------------------------------------------
// Usage:
// The input side is a queue write port: a transaction completes on a rising
// edge with push high and full low, carrying raw_byte and final_item. The
// output side is a queue read port: while empty is low the oldest result is
// on packed_byte, run_end and stream_done, and a transaction completes on a
// rising edge with pop high and empty low.
// One input transaction yields zero to five output bytes. The front end
// takes a new byte every cycle while the queue has room; the back end emits
// one byte per cycle while pop is high, so the sustained rate is set by the
// output port. The first byte of an item is written into the batch queue,
// then loaded into the back end's output register, where it can be taken.
// A two-entry queue of batches separates both ends, so input keeps flowing
// while the receiver stalls until the queue fills; then full rises until
// pop frees space.
// Reset clears the carried partial byte, the queue, the output valid flag
// and the code tables, making every code length zero. The code tables are
// written through the APB port (64-bit registers at byte addresses 0, 8,
// 16, 24 and 32) while the encoder is idle; pready is always high.
// ---------------------------------------------------------------------------
module nibble_prefix_code_encoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    // Input channel
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  raw_byte,
    input  wire logic        final_item,
    // Output channel
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       packed_byte,
    output logic             run_end,
    output logic             stream_done
);
    import npce_pkg::*;

    cfg_t   cfg;
    entry_t f_entry;
    entry_t q_data;
    logic   f_push;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    logic   accept;

    // An input transaction is taken whenever the batch queue has room.
    assign full   = q_full;
    assign accept = push && !q_full;

    npce_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The front end packs the codewords and drops batches with no bytes.
    npce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .accept     (accept),
        .raw_byte   (raw_byte),
        .final_item (final_item),
        .q_push     (f_push),
        .q_entry    (f_entry)
    );

    npce_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_data (f_entry),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    // The back end holds the current batch and serves as the output register.
    npce_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .packed_byte (packed_byte),
        .run_end     (run_end),
        .stream_done (stream_done)
    );

endmodule : nibble_prefix_code_encoder_top
`default_nettype wire

@@ design/npce_cfg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// npce_cfg: configuration register file
// APB-style write and read access to the code table and the length table.
// ---------------------------------------------------------------------------
module npce_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [5:0]    paddr,
    input  wire logic [63:0]   pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output npce_pkg::cfg_t     cfg
);
    import npce_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[5:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            if (idx == REG_LENGTHS)
            begin
                cfg_next.lengths = pwdata;
            end
            else if (idx < REG_LENGTHS)
            begin
                cfg_next.codes[idx[1:0]] = pwdata;
            end
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CODES_0: prdata = cfg_reg.codes[0];
            REG_CODES_1: prdata = cfg_reg.codes[1];
            REG_CODES_2: prdata = cfg_reg.codes[2];
            REG_CODES_3: prdata = cfg_reg.codes[3];
            REG_LENGTHS: prdata = cfg_reg.lengths;
            default:     prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule : npce_cfg
`default_nettype wire

@@ design/npce_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// npce_front: symbol lookup and bit packing
// Appends both nibble codewords to the carried partial byte and forms a
// batch of output bytes for the back end.
// ---------------------------------------------------------------------------
module npce_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire npce_pkg::cfg_t  cfg,
    input  wire logic            accept,
    input  wire logic [7:0]      raw_byte,
    input  wire logic            final_item,
    output logic                 q_push,
    output npce_pkg::entry_t     q_entry
);
    import npce_pkg::*;

    logic [2:0]        fill_reg;
    logic [2:0]        fill_next;
    logic [6:0]        resid_reg;
    logic [6:0]        resid_next;
    logic [3:0]        len0;
    logic [3:0]        len1;
    logic [15:0]       code0;
    logic [15:0]       code1;
    logic [4:0]        shift1;
    logic [5:0]        total;
    logic [2:0]        nfull;
    logic              flush;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] rest;

    function automatic logic [3:0] len_of(input cfg_t c, input logic [3:0] s);
        logic [3:0] l;
        l = c.lengths[{s, 2'b00} +: 4];
        if (32'(l) > MAX_CODE_LENGTH)
        begin
            l = 4'(MAX_CODE_LENGTH);
        end
        return l;
    endfunction

    function automatic logic [15:0] code_of(input cfg_t c, input logic [3:0] s,
                                            input logic [3:0] l);
        logic [15:0] w;
        w = c.codes[s[3:2]][{s[1:0], 4'b0000} +: 16];
        return w & ~(16'hFFFF << l);
    endfunction

    assign len0   = len_of(cfg, raw_byte[3:0]);
    assign len1   = len_of(cfg, raw_byte[7:4]);
    assign code0  = code_of(cfg, raw_byte[3:0], len0);
    assign code1  = code_of(cfg, raw_byte[7:4], len1);
    assign shift1 = 5'(fill_reg) + 5'(len0);
    assign total  = 6'(shift1) + 6'(len1);
    assign nfull  = total[5:3];
    assign flush  = final_item && (total[2:0] != 3'd0);

    // Carried bits sit at the bottom; new code bits follow in stream order.
    assign word = {33'd0, resid_reg}
                | ({24'd0, code0} << fill_reg)
                | ({24'd0, code1} << shift1);
    assign rest = word >> {nfull, 3'b000};

    assign q_entry.word = word;
    assign q_entry.cnt  = nfull + {2'b00, flush};
    assign q_entry.fin  = final_item;
    assign q_push       = accept && (q_entry.cnt != 3'd0);

    always_comb
    begin
        fill_next  = fill_reg;
        resid_next = resid_reg;
        if (accept)
        begin
            if (final_item)
            begin
                fill_next  = 3'd0;
                resid_next = 7'd0;
            end
            else
            begin
                fill_next  = total[2:0];
                resid_next = rest[6:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= 3'd0;
            resid_reg <= 7'd0;
        end
        else
        begin
            fill_reg  <= fill_next;
            resid_reg <= resid_next;
        end
    end

endmodule : npce_front
`default_nettype wire

@@ design/npce_fifo.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// npce_fifo: batch queue
// Short queue of byte batches between the front end and the back end.
// ---------------------------------------------------------------------------
module npce_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire npce_pkg::entry_t  wr_data,
    input  wire logic              rd_en,
    output npce_pkg::entry_t       rd_data,
    output logic                   full,
    output logic                   empty
);
    import npce_pkg::*;

    localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    entry_t          mem [QDEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [PtrW:0]   count_reg;
    logic [PtrW:0]   count_next;
    logic            do_wr;
    logic            do_rd;

    assign full    = (count_reg == (PtrW+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
        return (32'(p) == QDEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = do_wr ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_rd ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule : npce_fifo
`default_nettype wire

@@ design/npce_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// npce_back: byte emitter
// Takes one batch at a time from the queue and presents its bytes in order.
// ---------------------------------------------------------------------------
module npce_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire npce_pkg::entry_t  q_data,
    output logic                   q_pop,
    output logic                   empty,
    input  wire logic              pop,
    output logic [7:0]             packed_byte,
    output logic                   run_end,
    output logic                   stream_done
);
    import npce_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [2:0]        left_reg;
    logic [2:0]        left_next;
    logic              fin_reg;
    logic              fin_next;
    logic              valid_reg;
    logic              valid_next;
    logic              last;
    logic              take;

    assign last        = (left_reg == 3'd1);
    assign take        = pop && valid_reg;
    assign q_pop       = !q_empty && (!valid_reg || (take && last));
    assign empty       = !valid_reg;
    assign packed_byte = word_reg[7:0];
    assign run_end     = last;
    assign stream_done = last && fin_reg;

    always_comb
    begin
        word_next  = word_reg;
        left_next  = left_reg;
        fin_next   = fin_reg;
        valid_next = valid_reg;
        if (q_pop)
        begin
            word_next  = q_data.word;
            left_next  = q_data.cnt;
            fin_next   = q_data.fin;
            valid_next = 1'b1;
        end
        else if (take)
        begin
            if (last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                word_next = {8'd0, word_reg[WORD_W-1:8]};
                left_next = left_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        fin_reg  <= fin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            left_reg  <= left_next;
            valid_reg <= valid_next;
        end
    end

endmodule : npce_back
`default_nettype wire

@@ verif/tb_nibble_prefix_code_encoder_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_nibble_prefix_code_encoder_top: self-checking bench of the prefix-code encoder
// Loads code tables over APB, streams raw bytes through the input queue port
// and compares every packed output byte against an in-bench bit packer.
// ---------------------------------------------------------------------------
module tb_nibble_prefix_code_encoder_top;

    import npce_pkg::*;

    // Indexes past the register file. Writes to them must change nothing.
    localparam logic [2:0] REG_SPARE_LAST = 3'd7;

    // Cycles without any accepted transaction before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 300;

    // A byte can produce zero results, so after the last expected result the
    // encoder may still be busy. This setting covers that with margin.
    localparam int SETTLE_CYCLES = 12;

    localparam int PHASE_COUNT = 7;
    localparam int ITEMS_PER_PHASE = 60;

    typedef enum int {TABLE_LONGEST, TABLE_SHORT, TABLE_MIXED} table_style_t;

    typedef struct {
        logic [7:0] packed_byte;
        logic       run_end;
        logic       stream_done;
    } byte_result_t;

    // Bit packer that mirrors the encoder. It keeps its own copy of the code
    // table, the carried bits and the carried bit count, and queues the bytes
    // each raw byte should produce.
    class packed_byte_scoreboard;
        logic [63:0]  code_table [REG_COUNT];
        logic [36:0]  bit_acc;
        logic [2:0]   held_bits;
        byte_result_t expected_bytes [$];
        int           error_count;

        function new();
            foreach (code_table[i])
                code_table[i] = '0;
            bit_acc = '0;
            held_bits = '0;
            error_count = 0;
        endfunction

        function void write_table(logic [2:0] idx, logic [63:0] value);
            if (idx < REG_COUNT)
                code_table[idx] = value;
        endfunction

        // Appends the codeword of one symbol and returns the new fill level.
        function int append_code(logic [3:0] sym, int fill);
            int          len;
            logic [15:0] code;
            logic [63:0] wide;
            len = int'(code_table[REG_LENGTHS][4*sym +: 4]);
            if (len > MAX_CODE_LENGTH)
                len = MAX_CODE_LENGTH;
            code = code_table[sym >> 2][16*sym[1:0] +: 16];
            code = code & 16'((32'd1 << len) - 1);
            wide = 64'(code) << fill;
            bit_acc = bit_acc | wide[36:0];
            return fill + len;
        endfunction

        function void note_raw_byte(logic [7:0] raw, logic fin);
            int           fill;
            byte_result_t r;
            byte_result_t batch [$];
            fill = int'(held_bits);
            fill = append_code(raw[3:0], fill);
            fill = append_code(raw[7:4], fill);
            r.run_end = 1'b0;
            r.stream_done = 1'b0;
            while (fill >= 8)
            begin
                r.packed_byte = bit_acc[7:0];
                batch = {batch, r};
                bit_acc = bit_acc >> 8;
                fill -= 8;
            end
            if (fin)
            begin
                // Flush the partial byte; its unused high bits are already zero.
                if (fill > 0)
                begin
                    r.packed_byte = bit_acc[7:0];
                    batch = {batch, r};
                end
                bit_acc = '0;
                fill = 0;
            end
            if (batch.size() > 0)
            begin
                batch[batch.size()-1].run_end = 1'b1;
                batch[batch.size()-1].stream_done = fin;
            end
            held_bits = 3'(fill);
            foreach (batch[i])
                expected_bytes = {expected_bytes, batch[i]};
        endfunction

        function void check_packed_byte(logic [7:0] pb, logic re, logic sd);
            byte_result_t want;
            if (expected_bytes.size() == 0)
            begin
                $error("packed_byte 0x%02h arrived with no transaction expected", pb);
                error_count++;
                return;
            end
            want = expected_bytes.pop_front();
            if (pb !== want.packed_byte)
            begin
                $error("packed_byte mismatch: expected 0x%02h, actual 0x%02h",
                       want.packed_byte, pb);
                error_count++;
            end
            if (re !== want.run_end)
            begin
                $error("run_end mismatch: expected %b, actual %b", want.run_end, re);
                error_count++;
            end
            if (sd !== want.stream_done)
            begin
                $error("stream_done mismatch: expected %b, actual %b", want.stream_done, sd);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    logic [7:0]  raw_byte;
    logic        final_item;
    logic        empty;
    logic        pop;
    logic [7:0]  packed_byte;
    logic        run_end;
    logic        stream_done;

    packed_byte_scoreboard sb = new();

    // Table image that program_table loads into the encoder.
    logic [63:0] staged [REG_COUNT];

    // Idle control shared by the sender and the receiver.
    bit no_idle = 1'b0;
    int rx_hold_request = 0;
    int idle_cycles = 0;

    nibble_prefix_code_encoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .raw_byte    (raw_byte),
        .final_item  (final_item),
        .empty       (empty),
        .pop         (pop),
        .packed_byte (packed_byte),
        .run_end     (run_end),
        .stream_done (stream_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap lengths: mostly back to back, some short pauses, a few long ones.
    // During a no-idle stretch both sides run flat out.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Both ports are sampled at the rising edge, before any nonblocking update
    // of that edge lands, so the values seen are the ones the encoder saw.
    // Every input transaction feeds the packer and every output transaction is
    // checked against the oldest queued byte.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_raw_byte(raw_byte, final_item);
            if (pop && !empty)
                sb.check_packed_byte(packed_byte, run_end, stream_done);
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Hang detector. A lost byte leaves the bench waiting in a drain with no
    // traffic, which also ends up here.
    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Receiver. It pops with random gaps, and when the stimulus asks for a
    // hold-off it keeps pop low for a long stretch that it counts itself, so
    // the queue fills and full pushes back on the sender.
    initial
    begin
        int gap_left;
        int hold_left;
        gap_left = 0;
        hold_left = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_request > 0)
            begin
                hold_left = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                pop <= 1'b0;
                gap_left--;
            end
            else
            begin
                pop <= 1'b1;
                gap_left = pick_gap();
            end
        end
    end

    // APB write. It leaves psel high at the end so that a following access can
    // start in the same cycle; program_table drops it after the last access.
    task automatic apb_write(logic [2:0] idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_table(idx, value);
    endtask

    task automatic apb_read_check(logic [2:0] idx);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 3'b000};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== sb.code_table[idx])
        begin
            $error("prdata mismatch at register %0d: expected 0x%016h, actual 0x%016h",
                   idx, sb.code_table[idx], prdata);
            sb.error_count++;
        end
    endtask

    // Loads the staged table, hits one address past the register file, and
    // reads everything back to confirm the stray write changed nothing.
    task automatic program_table();
        for (int i = 0; i < REG_COUNT; i++)
            apb_write(3'(i), staged[i]);
        apb_write(3'($urandom_range(REG_COUNT, REG_SPARE_LAST)), {$urandom, $urandom});
        for (int i = 0; i < REG_COUNT; i++)
            apb_read_check(3'(i));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void set_symbol(int s, logic [15:0] code, logic [3:0] len);
        staged[s/4][16*(s%4) +: 16] = code;
        staged[REG_LENGTHS][4*s +: 4] = len;
    endfunction

    // Random codewords may carry stray bits above their length.
    function automatic void randomize_table(table_style_t style);
        logic [3:0] len;
        for (int s = 0; s < SYMBOL_COUNT; s++)
        begin
            case (style)
                TABLE_LONGEST: len = 4'(MAX_CODE_LENGTH);
                TABLE_SHORT:   len = 4'($urandom_range(1, 2));
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:       len = 4'd0;
                        1:       len = 4'(MAX_CODE_LENGTH);
                        default: len = 4'($urandom_range(1, MAX_CODE_LENGTH));
                    endcase
                end
            endcase
            set_symbol(s, 16'($urandom), len);
        end
    endfunction

    // Offers one raw byte and returns at the edge where it is taken. The
    // caller is always at a rising edge, so push is raised once per step.
    task automatic send_raw(logic [7:0] b, logic fin);
        push <= 1'b1;
        raw_byte <= b;
        final_item <= fin;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic offer_raw(logic [7:0] b, logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        send_raw(b, fin);
    endtask

    // Stops sending and waits until every queued byte has come out, then
    // gives the encoder time to finish bytes that produce no output.
    task automatic wait_until_drained();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int         r;
        logic [7:0] b;
        logic       fin;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        raw_byte = '0;
        final_item = 1'b0;
        foreach (staged[i])
            staged[i] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight out of reset every length is zero: no symbol adds bits, so
        // nothing comes out, not even for the final byte.
        offer_raw(8'h00, 1'b0);
        offer_raw(8'hA5, 1'b0);
        offer_raw(8'hFF, 1'b1);
        wait_until_drained();

        // Longest codes with every bit set, stray bit 15 included. Two symbols
        // plus carried bits reach 36 bits; a final flush yields the five-byte worst case.
        for (int s = 0; s < SYMBOL_COUNT; s++)
            set_symbol(s, 16'hFFFF, 4'(MAX_CODE_LENGTH));
        program_table();
        offer_raw(8'h00, 1'b0);
        offer_raw(8'hFF, 1'b0);
        offer_raw(8'h5A, 1'b1);
        offer_raw(8'h0F, 1'b1);
        wait_until_drained();

        // Four-bit codes equal to the symbol, with junk above the length. Each
        // byte maps back onto itself, and a final byte that lands on a byte
        // boundary must mark the full byte as the end of the stream.
        for (int s = 0; s < SYMBOL_COUNT; s++)
            set_symbol(s, 16'hFFF0 | 16'(s), 4'd4);
        program_table();
        offer_raw(8'h21, 1'b0);
        offer_raw(8'h43, 1'b0);
        offer_raw(8'h65, 1'b1);
        offer_raw(8'h87, 1'b1);
        offer_raw(8'hFE, 1'b0);
        offer_raw(8'hDC, 1'b1);
        wait_until_drained();

        // Length equals the symbol value, so symbol zero adds nothing and a
        // final byte of two zero symbols on a fresh stream has nothing to flush.
        for (int s = 0; s < SYMBOL_COUNT; s++)
            set_symbol(s, 16'($urandom), 4'(s));
        program_table();
        offer_raw(8'h00, 1'b1);
        offer_raw(8'h00, 1'b0);
        offer_raw(8'h10, 1'b1);
        offer_raw(8'hF1, 1'b0);
        offer_raw(8'hFF, 1'b0);
        offer_raw(8'h8E, 1'b1);
        offer_raw(8'h00, 1'b1);
        wait_until_drained();

        // Random streams, one table per phase. Each phase ends on a final byte
        // so the table changes between streams.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:       randomize_table(TABLE_LONGEST);
                1:       randomize_table(TABLE_SHORT);
                default: randomize_table(TABLE_MIXED);
            endcase
            program_table();
            // One phase runs with no idling on either side.
            no_idle = (ph == 3);
            // Receiver backs off while the sender keeps pushing, so the
            // batch queue fills and full has to hold the input.
            if (ph == 2)
                rx_hold_request = RX_HOLD_CYCLES;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Sender stops mid-stream until everything has come out.
                if (ph == 4 && k == ITEMS_PER_PHASE / 2)
                    wait_until_drained();
                r = $urandom_range(0, 9);
                if (r == 0)
                    b = 8'h00;
                else if (r == 1)
                    b = 8'hFF;
                else
                    b = 8'($urandom);
                fin = (k == ITEMS_PER_PHASE - 1) || ($urandom_range(0, 11) == 0);
                offer_raw(b, fin);
            end
            wait_until_drained();
        end
        no_idle = 1'b0;

        if (sb.error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/npce_pkg.sv
design/npce_cfg.sv
design/npce_front.sv
design/npce_fifo.sv
design/npce_back.sv
design/nibble_prefix_code_encoder_top.sv
verif/tb_nibble_prefix_code_encoder_top.sv
